// ===== sv/life_generation_step_core_defines.svh =====
// Assertion macros for the life generation step core.
// Used by the RTL files in this folder; relies on clk and rst_n in scope.
`ifndef LIFE_GENERATION_STEP_CORE_DEFINES_SVH
`define LIFE_GENERATION_STEP_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, gated by reset
`define LGE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, gated by reset
`define LGE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define LGE_ASSERT_IMP(lbl, ante, cons)
`define LGE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== sv/lge_pkg.sv =====
// Shared constants, types and helpers for the life generation step core.
// No dependencies; imported by every module of the block.
`default_nettype none

package lge_pkg;

  // Board geometry
  localparam int BOARD_ROWS = 32;
  localparam int BOARD_COLS = 32;

  // Fixed request/response field widths
  localparam int ROW_IDX_W = 5;
  localparam int BITS_W    = 32;

  localparam int ADDR_W = (BOARD_ROWS > 1) ? $clog2(BOARD_ROWS) : 1;
  localparam int CNT_W  = $clog2(BOARD_ROWS + 2);

  typedef logic [BOARD_COLS-1:0] row_word_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Request action codes (code 3 is a no-op)
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  // Board memory port bundle
  typedef struct packed {
    logic      wr_en;
    addr_t     wr_addr;
    row_word_t wr_data;
    logic      rd_en;
    addr_t     rd_addr;
  } mem_req_t;

  // Request bits to a board row; columns past the board are dropped
  function automatic row_word_t to_word(input logic [BITS_W-1:0] bits);
    row_word_t w;
    w = '0;
    for (int c = 0; c < BOARD_COLS && c < BITS_W; c++) begin
      w[c] = bits[c];
    end
    return w;
  endfunction

  // Board row to response bits; columns past 32 are not visible
  function automatic logic [BITS_W-1:0] from_word(input row_word_t w);
    logic [BITS_W-1:0] bits;
    bits = '0;
    for (int c = 0; c < BOARD_COLS && c < BITS_W; c++) begin
      bits[c] = w[c];
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

// ===== sv/life_generation_step_core.sv =====
// Life generation step core: top level with request sequencer and response register.
// Uses lge_pkg, lge_board_mem, lge_rule_unit and the assertion macro header.
//
// Usage:
//   Request channel (in_valid/in_ready): in_action selects write row (0),
//   read row (1) or advance one generation (2); code 3 changes nothing.
//   in_row picks the row for write/read, in_row_bits carries the row to write.
//   Response channel (out_valid/out_ready): exactly one response per request.
//   out_row_bits_out holds the row read (zero otherwise); out_generation_done
//   is set for an advance.
// Sequencing:
//   A write or no-op passes through the emit step only, a read through the
//   read and emit steps, an advance through the board sweep and then emit; the
//   next request is taken once the response is registered. The advance streams rows
//   through the one read port into a three-row window feeding one shared rule
//   unit, writing each new row back two rows behind the read pointer.
// Reset: synchronous, active low; the whole board reads as dead afterwards.
// Stall: a response waits in the output register while out_ready is low; the
//   next request is taken meanwhile and holds in its last step until the
//   output register is free.
`default_nettype none

`include "life_generation_step_core_defines.svh"

module life_generation_step_core
  import lge_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_action,
  input  wire logic [ROW_IDX_W-1:0] in_row,
  input  wire logic [BITS_W-1:0]    in_row_bits,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [BITS_W-1:0]         out_row_bits_out,
  output logic                      out_generation_done
);

  localparam cnt_t LAST_CNT = CNT_W'(BOARD_ROWS + 1);

  state_t            state_r, state_nxt;
  cnt_t              cnt_r, cnt_nxt;
  row_word_t         up_r, up_nxt;
  row_word_t         mid_r, mid_nxt;
  logic [BITS_W-1:0] res_bits_r, res_bits_nxt;
  logic              res_done_r, res_done_nxt;
  logic              row_ok_r, row_ok_nxt;
  logic              out_valid_r;
  logic [BITS_W-1:0] out_bits_r;
  logic              out_done_r;

  mem_req_t          mem_req;
  row_word_t         mem_rdata;
  row_word_t         below_row;
  row_word_t         rule_next;
  logic              in_row_ok;
  addr_t             in_addr;
  logic              emit_go;

  lge_board_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rdata)
  );

  lge_rule_unit u_rule (
    .row_above (up_r),
    .row_here  (mid_r),
    .row_below (below_row),
    .row_next  (rule_next)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_row_ok = (int'(in_row) < BOARD_ROWS);
  assign in_addr   = ADDR_W'(in_row);
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  // Below the last row the board is dead
  assign below_row = (cnt_r <= CNT_W'(BOARD_ROWS)) ? mem_rdata : '0;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer datapath registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    res_bits_r <= res_bits_nxt;
    res_done_r <= res_done_nxt;
    row_ok_r   <= row_ok_nxt;
  end

  // Next state, memory requests and window shifting
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    up_nxt       = up_r;
    mid_nxt      = mid_r;
    res_bits_nxt = res_bits_r;
    res_done_nxt = res_done_r;
    row_ok_nxt   = row_ok_r;
    mem_req      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_bits_nxt = '0;
          res_done_nxt = 1'b0;
          case (in_action)
            ACT_WRITE: begin
              mem_req.wr_en   = in_row_ok;
              mem_req.wr_addr = in_addr;
              mem_req.wr_data = to_word(in_row_bits);
              state_nxt       = ST_EMIT;
            end
            ACT_READ: begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = in_addr;
              row_ok_nxt      = in_row_ok;
              state_nxt       = ST_RD;
            end
            ACT_ADVANCE: begin
              cnt_nxt   = '0;
              up_nxt    = '0;
              mid_nxt   = '0;
              state_nxt = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_RD: begin
        res_bits_nxt = row_ok_r ? from_word(mem_rdata) : '0;
        state_nxt    = ST_EMIT;
      end
      ST_SWEEP: begin
        // Read ahead one row per step
        if (cnt_r < CNT_W'(BOARD_ROWS)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_W'(cnt_r);
        end
        // Row cnt-1 has arrived; slide the window
        if (cnt_r != '0) begin
          up_nxt  = mid_r;
          mid_nxt = below_row;
        end
        // Write back the row two behind the read pointer
        if (cnt_r >= CNT_W'(2)) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = ADDR_W'(cnt_r - CNT_W'(2));
          mem_req.wr_data = rule_next;
        end
        if (cnt_r == LAST_CNT) begin
          res_done_nxt = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_bits_r <= res_bits_r;
      out_done_r <= res_done_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_row_bits_out    = out_bits_r;
  assign out_generation_done = out_done_r;

  // Checks
  `LGE_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `LGE_ASSERT_NXT(a_adv_starts_sweep,
      in_valid && in_ready && (in_action == ACT_ADVANCE),
      (state_r == ST_SWEEP) && (cnt_r == '0))
  `LGE_ASSERT_IMP(a_done_has_no_bits,
      out_valid && out_generation_done, out_row_bits_out == '0)
  `LGE_ASSERT_IMP(a_wr_addr_in_board,
      mem_req.wr_en, int'(mem_req.wr_addr) < BOARD_ROWS)
  `LGE_ASSERT_IMP(a_no_rw_same_row,
      mem_req.wr_en && mem_req.rd_en, mem_req.wr_addr != mem_req.rd_addr)

endmodule

`default_nettype wire

// ===== sv/lge_board_mem.sv =====
// Board row storage: one write port, one registered read port.
// Per-row valid bits make unwritten rows read as dead. Uses lge_pkg.
`default_nettype none

module lge_board_mem
  import lge_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire mem_req_t  req,
  output row_word_t      rd_data
);

  row_word_t             mem_r [BOARD_ROWS];
  logic [BOARD_ROWS-1:0] valid_r;
  row_word_t             rd_word_r;
  logic                  rd_valid_r;

  // Storage array, no reset
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= mem_r[req.rd_addr];
    end
  end

  // Row valid bits and read-side valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule

`default_nettype wire

// ===== sv/lge_rule_unit.sv =====
// B3/S23 row update: new row from the old rows above, at and below.
// Cells past the left and right edges count as dead. Uses lge_pkg.
`default_nettype none

module lge_rule_unit
  import lge_pkg::*;
(
  input  wire row_word_t row_above,
  input  wire row_word_t row_here,
  input  wire row_word_t row_below,
  output row_word_t      row_next
);

  logic [BOARD_COLS+1:0] pad_above;
  logic [BOARD_COLS+1:0] pad_here;
  logic [BOARD_COLS+1:0] pad_below;

  // One dead column on each side
  assign pad_above = {1'b0, row_above, 1'b0};
  assign pad_here  = {1'b0, row_here, 1'b0};
  assign pad_below = {1'b0, row_below, 1'b0};

  // Independent per-cell neighbor count and rule
  always_comb begin
    logic [3:0] count;
    row_next = '0;
    for (int c = 0; c < BOARD_COLS; c++) begin
      count = 4'(pad_above[c]) + 4'(pad_above[c+1]) + 4'(pad_above[c+2])
            + 4'(pad_here[c])                      + 4'(pad_here[c+2])
            + 4'(pad_below[c]) + 4'(pad_below[c+1]) + 4'(pad_below[c+2]);
      row_next[c] = (count == 4'd3) || (row_here[c] && (count == 4'd2));
    end
  end

endmodule

`default_nettype wire

// ===== tb/life_generation_step_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for life_generation_step_core: row writes, row reads, no-ops and B3/S23 advances.
// Needs lge_pkg and the core RTL; checks every response against a hand-typed reply or an in-bench board predictor.

module life_generation_step_core_tb;
  import lge_pkg::*;

  // Unused action code: the core must leave the board alone and answer zero
  localparam logic [1:0] ACT_NOP = 2'd3;

  // Directed-table flags: response typed in by hand, or taken from the predictor
  localparam logic FIXED   = 1'b1;
  localparam logic PREDICT = 1'b0;

  localparam int OPENING_LEN     = 25;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int NUM_PHASES      = 4;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = BOARD_ROWS + 8;

  typedef struct packed {
    logic [BITS_W-1:0] row_bits;
    logic              generation_done;
  } life_reply_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [ROW_IDX_W-1:0] row;
    logic [BITS_W-1:0]    row_bits;
    logic                 fixed_reply;
    logic [BITS_W-1:0]    want_bits;
    logic                 want_done;
  } life_req_row_t;

  // Opening requests: edges of the board, every action, blinkers on both edge columns
  localparam life_req_row_t OPENING_ROWS [OPENING_LEN] = '{
    '{ACT_READ,    5'd0,  32'h0000_0000, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_READ,    5'd31, 32'hFFFF_FFFF, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_WRITE,   5'd0,  32'hFFFF_FFFF, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_WRITE,   5'd31, 32'hFFFF_FFFF, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_READ,    5'd0,  32'h0000_0000, FIXED,   32'hFFFF_FFFF, 1'b0},
    '{ACT_READ,    5'd31, 32'h0000_0000, FIXED,   32'hFFFF_FFFF, 1'b0},
    '{ACT_NOP,     5'd31, 32'hFFFF_FFFF, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_ADVANCE, 5'd31, 32'hFFFF_FFFF, FIXED,   32'h0000_0000, 1'b1},
    '{ACT_READ,    5'd0,  32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
    '{ACT_READ,    5'd1,  32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
    '{ACT_READ,    5'd30, 32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
    '{ACT_WRITE,   5'd0,  32'h0000_0000, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_WRITE,   5'd1,  32'h0000_0000, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_WRITE,   5'd30, 32'h0000_0000, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_WRITE,   5'd31, 32'h0000_0000, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_WRITE,   5'd10, 32'h0000_0700, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_WRITE,   5'd20, 32'h8000_0001, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_WRITE,   5'd21, 32'h8000_0001, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_WRITE,   5'd22, 32'h8000_0001, FIXED,   32'h0000_0000, 1'b0},
    '{ACT_ADVANCE, 5'd0,  32'h0000_0000, FIXED,   32'h0000_0000, 1'b1},
    '{ACT_READ,    5'd10, 32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
    '{ACT_READ,    5'd9,  32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
    '{ACT_READ,    5'd21, 32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0},
    '{ACT_ADVANCE, 5'd0,  32'h0000_0000, FIXED,   32'h0000_0000, 1'b1},
    '{ACT_READ,    5'd11, 32'h0000_0000, PREDICT, 32'h0000_0000, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_action;
  logic [ROW_IDX_W-1:0] in_row;
  logic [BITS_W-1:0]    in_row_bits;
  logic                 out_valid;
  logic                 out_ready;
  logic [BITS_W-1:0]    out_row_bits_out;
  logic                 out_generation_done;

  // Predicted board and the replies still owed by the core
  logic [BOARD_COLS-1:0] life_board [BOARD_ROWS];
  life_reply_t           due_replies [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int mismatches         = 0;
  int replies_checked    = 0;
  int quiet_cycles       = 0;
  int n_writes           = 0;
  int n_reads            = 0;
  int n_advances         = 0;
  int n_nops             = 0;
  int n_live_reads       = 0;

  life_generation_step_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_row              (in_row),
    .in_row_bits         (in_row_bits),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_row_bits_out    (out_row_bits_out),
    .out_generation_done (out_generation_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cell of the current board; outside the board is dead
  function automatic int cell_at(int r, int c);
    if (r < 0 || r >= BOARD_ROWS || c < 0 || c >= BOARD_COLS) return 0;
    return int'(life_board[r][c]);
  endfunction

  // One synchronous B3/S23 generation, all from the old board
  function automatic void step_generation();
    logic [BOARD_COLS-1:0] next_gen [BOARD_ROWS];
    int neighbors;
    for (int r = 0; r < BOARD_ROWS; r++) begin
      for (int c = 0; c < BOARD_COLS; c++) begin
        neighbors = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) neighbors += cell_at(r + dr, c + dc);
          end
        end
        next_gen[r][c] = (neighbors == 3) || (neighbors == 2 && life_board[r][c]);
      end
    end
    life_board = next_gen;
  endfunction

  // Apply one request to the predicted board and return the reply it owes
  function automatic life_reply_t run_life_request(logic [1:0] act,
                                                   logic [ROW_IDX_W-1:0] row,
                                                   logic [BITS_W-1:0] bits);
    life_reply_t reply;
    reply = '0;
    case (act)
      ACT_WRITE: begin
        n_writes++;
        if (int'(row) < BOARD_ROWS) life_board[row] = BOARD_COLS'(bits);
      end
      ACT_READ: begin
        n_reads++;
        if (int'(row) < BOARD_ROWS) reply.row_bits = BITS_W'(life_board[row]);
        if (reply.row_bits != '0) n_live_reads++;
      end
      ACT_ADVANCE: begin
        n_advances++;
        step_generation();
        reply.generation_done = 1'b1;
      end
      default: begin
        n_nops++;
      end
    endcase
    return reply;
  endfunction

  // Drive one request from a falling edge and hold it until the core takes it
  task automatic send_request(logic [1:0] act, logic [ROW_IDX_W-1:0] row,
                              logic [BITS_W-1:0] bits, logic fixed_reply,
                              life_reply_t fixed_val);
    life_reply_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_row      <= row;
    in_row_bits <= bits;
    do @(posedge clk); while (!in_ready);
    predicted = run_life_request(act, row, bits);
    due_replies.push_back(fixed_reply ? fixed_val : predicted);
  endtask

  // Row contents with varied density so patterns both live and die out
  function automatic logic [BITS_W-1:0] random_row();
    case ($urandom_range(4))
      0: return $urandom & $urandom & $urandom;
      1: return $urandom & $urandom;
      2: return $urandom;
      3: return $urandom | $urandom;
      default: return (BITS_W'(7) << $urandom_range(BITS_W - 3));
    endcase
  endfunction

  // Receiver stall pattern
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Response checker: oldest owed reply against what the core returns
  always @(posedge clk) begin
    life_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: row_bits_out=%h generation_done=%b",
                   out_row_bits_out, out_generation_done);
      end else begin
        want = due_replies.pop_front();
        replies_checked++;
        if (want.row_bits !== out_row_bits_out ||
            want.generation_done !== out_generation_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response %0d mismatch: row_bits_out exp %h got %h, done exp %b got %b",
                     replies_checked, want.row_bits, out_row_bits_out,
                     want.generation_done, out_generation_done);
        end
      end
    end
  end

  // Watchdog: cycles without any request or response moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles, %0d responses owed",
                 quiet_cycles, due_replies.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    life_req_row_t entry;
    life_reply_t   fixed_val;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = ACT_NOP;
    in_row      = '0;
    in_row_bits = '0;
    for (int r = 0; r < BOARD_ROWS; r++) life_board[r] = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening, no idling
    for (int i = 0; i < OPENING_LEN; i++) begin
      entry = OPENING_ROWS[i];
      fixed_val.row_bits        = entry.want_bits;
      fixed_val.generation_done = entry.want_done;
      send_request(entry.action, entry.row, entry.row_bits, entry.fixed_reply, fixed_val);
    end

    // Random traffic across idle/stall phases
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
        default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 34)
          send_request(ACT_WRITE, ROW_IDX_W'($urandom_range(BOARD_ROWS - 1)),
                       random_row(), PREDICT, '0);
        else if (pick < 68)
          send_request(ACT_READ, ROW_IDX_W'($urandom_range(BOARD_ROWS - 1)),
                       $urandom, PREDICT, '0);
        else if (pick < 93)
          send_request(ACT_ADVANCE, ROW_IDX_W'($urandom), $urandom, PREDICT, '0);
        else
          send_request(ACT_NOP, ROW_IDX_W'($urandom), $urandom, PREDICT, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    sender_idle_pct = 0;

    // Drain: everything owed, then a tail long enough for a full sweep
    while (due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d writes, %0d reads (%0d with live cells), %0d advances, %0d no-ops",
             n_writes, n_reads, n_live_reads, n_advances, n_nops);
    $display("%0d responses checked, %0d mismatches", replies_checked, mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/lge_pkg.sv
sv/lge_board_mem.sv
sv/lge_rule_unit.sv
sv/life_generation_step_core.sv
tb/life_generation_step_core_tb.sv
